// ===== rtl/karmarkar_karp_heap_partition_defines.svh =====
// Assertion macros shared by the heap partition RTL.
// No dependencies; included by the top level only.
`ifndef KARMARKAR_KARP_HEAP_PARTITION_DEFINES_SVH
`define KARMARKAR_KARP_HEAP_PARTITION_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define KKHP_ASSERT_SAME(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define KKHP_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/kkhp_pkg.sv =====
// Shared types and constants of the heap partition block.
// No dependencies; imported by the controller, the datapath and the top level.
`timescale 1ns / 1ps

package kkhp_pkg;

    localparam int CAPACITY_DEF   = 128;
    localparam int VALUE_BITS_DEF = 40;
    localparam int VALUE_W        = 40;
    localparam int RESIDUE_W      = 40;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic               last;
    } in_beat_t;

    typedef struct packed {
        logic [RESIDUE_W-1:0] residue;
        logic                 overflowed;
    } out_beat_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_UP_RD,
        ST_UP_CMP,
        ST_LOOP,
        ST_POP_RD,
        ST_POP_LD,
        ST_DN_RD,
        ST_DN_CMP,
        ST_EMIT
    } state_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_ACCEPT,
        OP_UP_RD,
        OP_WR_HOLE,
        OP_UP_MOVE,
        OP_POP_RD,
        OP_POP_LD,
        OP_DN_RD,
        OP_DN_MOVE,
        OP_FIN_RD,
        OP_EMIT
    } op_t;

    typedef struct packed {
        op_t  op;
        logic pop_done;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic in_last;
        logic n_is_root;
        logic parent_lt;
        logic leaf;
        logic big_is_n;
        logic cnt_gt1;
        logic pop_idx;
        logic last_flag;
        logic dropped;
        logic out_free;
    } status_t;

endpackage

// ===== rtl/kkhp_ram.sv =====
// Generic RAM: one write port, two read ports with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module kkhp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_a,
    output logic [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_a <= mem[raddr_a];
            rdata_b <= mem[raddr_b];
        end
    end

endmodule

// ===== rtl/kkhp_ctrl.sv =====
// Sequencer for heap insert, extract and differencing.
// Depends on kkhp_pkg; drives the datapath through cmd_t.
`timescale 1ns / 1ps

module kkhp_ctrl import kkhp_pkg::*; (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    s_valid,
    output logic    s_ready,
    input  status_t status,
    output cmd_t    cmd
);

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    if (!status.full) begin
                        state_next = ST_UP_RD;
                    end else if (status.in_last) begin
                        state_next = ST_LOOP;
                    end
                end
            end
            ST_UP_RD: begin
                if (!status.n_is_root) begin
                    state_next = ST_UP_CMP;
                end else begin
                    state_next = status.last_flag ? ST_LOOP : ST_IDLE;
                end
            end
            ST_UP_CMP: begin
                if (status.parent_lt) begin
                    state_next = ST_UP_RD;
                end else begin
                    state_next = status.last_flag ? ST_LOOP : ST_IDLE;
                end
            end
            ST_LOOP: begin
                state_next = status.cnt_gt1 ? ST_POP_LD : ST_EMIT;
            end
            ST_POP_RD: state_next = ST_POP_LD;
            ST_POP_LD: state_next = ST_DN_RD;
            ST_DN_RD: begin
                if (!status.leaf) begin
                    state_next = ST_DN_CMP;
                end else begin
                    state_next = status.pop_idx ? ST_UP_RD : ST_POP_RD;
                end
            end
            ST_DN_CMP: begin
                if (!status.big_is_n) begin
                    state_next = ST_DN_RD;
                end else begin
                    state_next = status.pop_idx ? ST_UP_RD : ST_POP_RD;
                end
            end
            ST_EMIT: begin
                if (status.out_free) begin
                    state_next = ST_IDLE;
                end
            end
        endcase
    end

    // outputs
    always_comb begin
        s_ready      = 1'b0;
        cmd.op       = OP_NONE;
        cmd.pop_done = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.op = OP_ACCEPT;
                end
            end
            ST_UP_RD: cmd.op = status.n_is_root ? OP_WR_HOLE : OP_UP_RD;
            ST_UP_CMP: cmd.op = status.parent_lt ? OP_UP_MOVE : OP_WR_HOLE;
            ST_LOOP: cmd.op = status.cnt_gt1 ? OP_POP_RD : OP_FIN_RD;
            ST_POP_RD: cmd.op = OP_POP_RD;
            ST_POP_LD: cmd.op = OP_POP_LD;
            ST_DN_RD: begin
                if (status.leaf) begin
                    cmd.op       = OP_WR_HOLE;
                    cmd.pop_done = 1'b1;
                end else begin
                    cmd.op = OP_DN_RD;
                end
            end
            ST_DN_CMP: begin
                if (status.big_is_n) begin
                    cmd.op       = OP_WR_HOLE;
                    cmd.pop_done = 1'b1;
                end else begin
                    cmd.op = OP_DN_MOVE;
                end
            end
            ST_EMIT: begin
                if (status.out_free) begin
                    cmd.op = OP_EMIT;
                end
            end
        endcase
    end

endmodule

// ===== rtl/kkhp_datapath.sv =====
// Heap storage, hole registers, counters and the result register.
// Depends on kkhp_pkg and kkhp_ram; commanded by kkhp_ctrl.
`timescale 1ns / 1ps

module kkhp_datapath import kkhp_pkg::*; #(
    parameter int CAPACITY   = CAPACITY_DEF,
    parameter int VALUE_BITS = VALUE_BITS_DEF
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  in_beat_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_beat_t m_data,
    input  cmd_t      cmd,
    output status_t   status
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int AW = $clog2(CAPACITY);
    localparam logic [CW-1:0] ONE       = CW'(1);
    localparam logic [CW-1:0] CAP_COUNT = CW'(CAPACITY);
    localparam logic [CW:0]   ONE_W     = (CW + 1)'(1);

    logic [CW-1:0]         count_reg, count_next;
    logic [CW-1:0]         n_reg, n_next;
    logic [VALUE_BITS-1:0] v_reg, v_next;
    logic [VALUE_BITS-1:0] a_reg, a_next;
    logic [VALUE_BITS-1:0] b_reg, b_next;
    logic                  drop_reg, drop_next;
    logic                  last_reg, last_next;
    logic                  pop_idx_reg, pop_idx_next;
    logic                  m_valid_reg, m_valid_next;
    out_beat_t             m_data_reg, m_data_next;

    logic                  we, re;
    logic [AW-1:0]         waddr, raddr_a, raddr_b;
    logic [VALUE_BITS-1:0] wdata, rdata_a, rdata_b;

    logic [CW:0]           left_pos, right_pos, count_ext, big_pos;
    logic [AW-1:0]         hole_addr, parent_addr, left_addr, right_addr;
    logic                  full, leaf, r_ok, l_gt, r_gt;
    logic [VALUE_BITS-1:0] bigv;

    kkhp_ram #(
        .WIDTH (VALUE_BITS),
        .DEPTH (CAPACITY)
    ) u_heap (
        .aclk    (aclk),
        .we      (we),
        .waddr   (waddr),
        .wdata   (wdata),
        .re      (re),
        .raddr_a (raddr_a),
        .raddr_b (raddr_b),
        .rdata_a (rdata_a),
        .rdata_b (rdata_b)
    );

    // heap positions are 1-based; address = position - 1
    assign left_pos    = {n_reg, 1'b0};
    assign right_pos   = {n_reg, 1'b1};
    assign count_ext   = {1'b0, count_reg};
    assign hole_addr   = AW'(n_reg - ONE);
    assign parent_addr = AW'((n_reg >> 1) - ONE);
    assign left_addr   = AW'(left_pos - ONE_W);
    assign right_addr  = AW'(right_pos - ONE_W);

    assign full = (count_reg >= CAP_COUNT);
    assign leaf = (left_pos > count_ext);
    assign r_ok = (right_pos <= count_ext);

    // larger child against the hole value; ties keep the earlier choice
    assign l_gt    = (rdata_a > v_reg);
    assign r_gt    = r_ok && (l_gt ? (rdata_b > rdata_a) : (rdata_b > v_reg));
    assign big_pos = r_gt ? right_pos : left_pos;
    assign bigv    = r_gt ? rdata_b : rdata_a;

    always_comb begin
        count_next   = count_reg;
        n_next       = n_reg;
        v_next       = v_reg;
        a_next       = a_reg;
        b_next       = b_reg;
        drop_next    = drop_reg;
        last_next    = last_reg;
        pop_idx_next = pop_idx_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        we           = 1'b0;
        re           = 1'b0;
        waddr        = hole_addr;
        wdata        = v_reg;
        raddr_a      = parent_addr;
        raddr_b      = left_addr;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (cmd.op)
            OP_NONE: begin
            end
            OP_ACCEPT: begin
                last_next = s_data.last;
                if (full) begin
                    drop_next = 1'b1;
                end else begin
                    count_next = count_reg + ONE;
                    n_next     = count_reg + ONE;
                    v_next     = VALUE_BITS'(s_data.value);
                end
            end
            OP_UP_RD: begin
                re      = 1'b1;
                raddr_a = parent_addr;
            end
            OP_WR_HOLE: begin
                we = 1'b1;
                if (cmd.pop_done) begin
                    pop_idx_next = !pop_idx_reg;
                    if (pop_idx_reg) begin
                        // second extract done: insert the difference
                        count_next = count_reg + ONE;
                        n_next     = count_reg + ONE;
                        v_next     = a_reg - b_reg;
                    end
                end
            end
            OP_UP_MOVE: begin
                we     = 1'b1;
                wdata  = rdata_a;
                n_next = n_reg >> 1;
            end
            OP_POP_RD: begin
                re         = 1'b1;
                raddr_a    = '0;
                raddr_b    = AW'(count_reg - ONE);
                count_next = count_reg - ONE;
            end
            OP_POP_LD: begin
                if (pop_idx_reg) begin
                    b_next = rdata_a;
                end else begin
                    a_next = rdata_a;
                end
                v_next = rdata_b;
                n_next = ONE;
            end
            OP_DN_RD: begin
                re      = 1'b1;
                raddr_a = left_addr;
                raddr_b = r_ok ? right_addr : left_addr;
            end
            OP_DN_MOVE: begin
                we     = 1'b1;
                wdata  = bigv;
                n_next = CW'(big_pos);
            end
            OP_FIN_RD: begin
                re      = 1'b1;
                raddr_a = '0;
            end
            OP_EMIT: begin
                m_valid_next           = 1'b1;
                m_data_next.residue    = (count_reg == ONE) ? RESIDUE_W'(rdata_a) : '0;
                m_data_next.overflowed = drop_reg;
                count_next             = '0;
                drop_next              = 1'b0;
                last_next              = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            drop_reg    <= 1'b0;
            last_reg    <= 1'b0;
            pop_idx_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            count_reg   <= count_next;
            drop_reg    <= drop_next;
            last_reg    <= last_next;
            pop_idx_reg <= pop_idx_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        n_reg      <= n_next;
        v_reg      <= v_next;
        a_reg      <= a_next;
        b_reg      <= b_next;
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    assign status.full      = full;
    assign status.in_last   = s_data.last;
    assign status.n_is_root = (n_reg == ONE);
    assign status.parent_lt = (rdata_a < v_reg);
    assign status.leaf      = leaf;
    assign status.big_is_n  = !l_gt && !r_gt;
    assign status.cnt_gt1   = (count_reg > ONE);
    assign status.pop_idx   = pop_idx_reg;
    assign status.last_flag = last_reg;
    assign status.dropped   = drop_reg;
    assign status.out_free  = !m_valid_reg || m_ready;

endmodule

// ===== rtl/karmarkar_karp_heap_partition.sv =====
// Insert: the new value climbs from the last position while its parent is smaller; a beat
// on a full heap is dropped. One heap RAM read and one write per level climbed or sunk.
// Last beat: that insert unless dropped, then count - 1 rounds of two extracts and one
// insert of the difference; then the last entry is read and emitted once the output is free.
// Reset (aresetn, synchronous, active low) empties the heap and clears the drop flag;
// heap RAM contents are not cleared, only live entries are ever read.
`timescale 1ns / 1ps
`include "karmarkar_karp_heap_partition_defines.svh"

module karmarkar_karp_heap_partition import kkhp_pkg::*; #(
    parameter int CAPACITY   = CAPACITY_DEF,
    parameter int VALUE_BITS = VALUE_BITS_DEF
) (
    input  logic      aclk,
    input  logic      aresetn,
    // input beats: one number of the set, last marks the end of the set
    input  logic      s_valid,
    output logic      s_ready,
    input  in_beat_t  s_data,
    // result beats: residue of the set and the overflow flag
    output logic      m_valid,
    input  logic      m_ready,
    output out_beat_t m_data
);

    // Controller steps the heap operations; the datapath holds the heap RAM,
    // the hole value under sift, the two extracted maxima and the result register.
    cmd_t    cmd;
    status_t status;

    kkhp_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    kkhp_datapath #(
        .CAPACITY   (CAPACITY),
        .VALUE_BITS (VALUE_BITS)
    ) u_datapath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .cmd     (cmd),
        .status  (status)
    );

    // A result beat appears only right after the controller issued an emit.
    `KKHP_ASSERT_SAME(a_result_from_emit, aclk, aresetn, $rose(m_valid),
        $past(cmd.op == OP_EMIT), "result beat without emit")

    // A beat accepted into a full heap must raise the drop flag.
    `KKHP_ASSERT_NEXT(a_drop_on_full, aclk, aresetn, s_valid && s_ready && status.full,
        status.dropped, "dropped beat not flagged")

    // The final read only happens once differencing has left one entry.
    `KKHP_ASSERT_SAME(a_final_single, aclk, aresetn, cmd.op == OP_FIN_RD,
        !status.cnt_gt1, "final read with several entries left")

    // After the emit the heap is empty and the set flags are cleared.
    `KKHP_ASSERT_NEXT(a_clear_after_emit, aclk, aresetn, cmd.op == OP_EMIT,
        !status.cnt_gt1 && !status.dropped && !status.last_flag, "set state not cleared")

endmodule
